[rtl/core/ms_adpcm_mono_block_decoder_top_macros.svh]
// ----------------------------------------------------------------------------
// ms_adpcm_mono_block_decoder_top_macros
// Assertion shorthands for the mono ADPCM block decoder. The macros expect
// clk_i and rst_ni in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef MS_ADPCM_MONO_BLOCK_DECODER_TOP_MACROS_SVH
`define MS_ADPCM_MONO_BLOCK_DECODER_TOP_MACROS_SVH

// Same-cycle implication.
`define MSADPCM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSADPCM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/msadpcm_pkg.sv]
// ----------------------------------------------------------------------------
// msadpcm_pkg
// Shared types, register indexes and tables of the mono ADPCM block decoder.
// ----------------------------------------------------------------------------
package msadpcm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CfgBlockBytes  = 3'd0;
  localparam logic [2:0] CfgFirstLow    = 3'd1;
  localparam logic [2:0] CfgFirstHigh   = 3'd2;
  localparam logic [2:0] CfgSecondLow   = 3'd3;
  localparam logic [2:0] CfgSecondHigh  = 3'd4;

  localparam logic [15:0] BlockBytesReset = 16'd256;
  localparam int unsigned QueueDepth      = 2;

  // What the back end has to do with a queued byte.
  typedef enum logic [2:0] {
    KIND_INDEX,
    KIND_LOW,
    KIND_DELTA,
    KIND_NEWER,
    KIND_OLDER,
    KIND_BODY
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        ends;
  } q_item_t;

  // Step delta adaptation factors, in 1/256 units.
  function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
    logic [9:0] f;
    case (nib)
      4'd4, 4'd12: f = 10'd307;
      4'd5, 4'd11: f = 10'd409;
      4'd6, 4'd10: f = 10'd512;
      4'd7, 4'd9:  f = 10'd614;
      4'd8:        f = 10'd768;
      default:     f = 10'd230;
    endcase
    return f;
  endfunction

endpackage

[rtl/core/ms_adpcm_mono_block_decoder_top.sv]
// ----------------------------------------------------------------------------
// ms_adpcm_mono_block_decoder_top
// Mono Microsoft ADPCM block decoder, one stream byte in, PCM samples out.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of the block stream enter on in_valid_i/in_ready_o. Decoded samples
// leave on out_valid_o/out_ready_i with last_of_run_o marking the final sample
// of a byte, end_of_block_o the last sample of a block and bad_predictor_o a
// wrapped predictor index. Registers are written on cfg_valid_i (always ready).
// The user must write them only while the block is idle; it is not enforced.
// The front end takes one byte per cycle while its queue has room. Header
// bytes before the last only load back-end state; the last one gives two
// samples. A body byte passes a fetch, then for each nibble two multiply
// steps, a sum, a scaling and a saturate step on the shared multiply/add
// chain; no new byte is fetched until both of its samples are out. The
// first sample of a body byte is registered after its fetch, multiply, sum
// and scaling steps. A stalled receiver holds the result register; the back
// end then waits and the queue, then in_ready_o, backs up.
// Reset returns to the start of a block with default registers and empty
// queue and result register.
// ----------------------------------------------------------------------------
`include "ms_adpcm_mono_block_decoder_top_macros.svh"

module ms_adpcm_mono_block_decoder_top #(
  parameter int unsigned QueueDepth = msadpcm_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic               last_of_run_o,
  output logic               end_of_block_o,
  output logic               bad_predictor_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  logic [15:0] block_bytes_q;
  logic [63:0] first_low_q, first_high_q, second_low_q, second_high_q;

  logic                 q_push, q_full, q_pop, q_valid;
  msadpcm_pkg::q_item_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= msadpcm_pkg::BlockBytesReset;
      first_low_q   <= 64'd0;
      first_high_q  <= 64'd0;
      second_low_q  <= 64'd0;
      second_high_q <= 64'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        msadpcm_pkg::CfgBlockBytes: block_bytes_q <= cfg_data_i[15:0];
        msadpcm_pkg::CfgFirstLow:   first_low_q   <= cfg_data_i;
        msadpcm_pkg::CfgFirstHigh:  first_high_q  <= cfg_data_i;
        msadpcm_pkg::CfgSecondLow:  second_low_q  <= cfg_data_i;
        msadpcm_pkg::CfgSecondHigh: second_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  msadpcm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .block_bytes_i (block_bytes_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  msadpcm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  msadpcm_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_item_i            (q_out),
    .q_pop_o             (q_pop),
    .first_coeff_low_i   (first_low_q),
    .first_coeff_high_i  (first_high_q),
    .second_coeff_low_i  (second_low_q),
    .second_coeff_high_i (second_high_q),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .sample_o            (sample_o),
    .last_of_run_o       (last_of_run_o),
    .end_of_block_o      (end_of_block_o),
    .bad_predictor_o     (bad_predictor_o)
  );

  // An accepted byte is waiting in the queue at the next edge at the latest.
  `MSADPCM_ASSERT_NXT(a_push_lands, in_valid_i && in_ready_o, q_valid, "accepted byte lost")
  // The back end only takes bytes that are really queued.
  `MSADPCM_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "pop from empty queue")
  // The end of a block is always the final sample of its byte.
  `MSADPCM_ASSERT_IMP(a_eob_last, out_valid_o && end_of_block_o, last_of_run_o,
                      "end of block without last of run")

endmodule

[rtl/core/msadpcm_front.sv]
// ----------------------------------------------------------------------------
// msadpcm_front
// Accepts stream bytes, tracks the position in the block and tags each byte
// with its role before it enters the queue.
// ----------------------------------------------------------------------------
module msadpcm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic [15:0]          block_bytes_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output msadpcm_pkg::q_item_t q_item_o
);

  localparam logic [15:0] PosIndex = 16'd0;
  localparam logic [15:0] PosDelta = 16'd2;
  localparam logic [15:0] PosNewer = 16'd4;
  localparam logic [15:0] PosOlder = 16'd6;

  logic [15:0] pos_q, pos_d;
  logic [15:0] last_pos;
  logic        ends;
  msadpcm_pkg::kind_e kind;

  // A block never ends before the full header has been read.
  assign last_pos = (block_bytes_i < 16'd7) ? PosOlder : block_bytes_i - 16'd1;
  assign ends     = pos_q >= last_pos;

  always_comb begin
    unique case (pos_q) inside
      PosIndex:                kind = msadpcm_pkg::KIND_INDEX;
      16'd1, 16'd3, 16'd5:     kind = msadpcm_pkg::KIND_LOW;
      PosDelta:                kind = msadpcm_pkg::KIND_DELTA;
      PosNewer:                kind = msadpcm_pkg::KIND_NEWER;
      PosOlder:                kind = msadpcm_pkg::KIND_OLDER;
      default:                 kind = msadpcm_pkg::KIND_BODY;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign q_item_o.kind = kind;
  assign q_item_o.data = data_byte_i;
  assign q_item_o.ends = ends;

  assign pos_d = ends ? 16'd0 : pos_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 16'd0;
    end else if (q_push_o) begin
      pos_q <= pos_d;
    end
  end

endmodule

[rtl/core/msadpcm_queue.sv]
// ----------------------------------------------------------------------------
// msadpcm_queue
// Short first-in first-out queue of tagged bytes between front and back end.
// ----------------------------------------------------------------------------
module msadpcm_queue #(
  parameter int unsigned Depth = msadpcm_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  msadpcm_pkg::q_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output msadpcm_pkg::q_item_t item_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  msadpcm_pkg::q_item_t mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/msadpcm_back.sv]
// ----------------------------------------------------------------------------
// msadpcm_back
// Executes queued bytes: loads the header state, decodes body nibbles over a
// short multiply/sum/scale sequence and drives the result register.
// ----------------------------------------------------------------------------
module msadpcm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  msadpcm_pkg::q_item_t q_item_i,
  output logic                 q_pop_o,
  input  logic [63:0]          first_coeff_low_i,
  input  logic [63:0]          first_coeff_high_i,
  input  logic [63:0]          second_coeff_low_i,
  input  logic [63:0]          second_coeff_high_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [15:0]   sample_o,
  output logic                 last_of_run_o,
  output logic                 end_of_block_o,
  output logic                 bad_predictor_o
);

  localparam logic [2:0] StFetch = 3'd0;
  localparam logic [2:0] StHdr0  = 3'd1;
  localparam logic [2:0] StHdr1  = 3'd2;
  localparam logic [2:0] StMul1  = 3'd3;
  localparam logic [2:0] StMul2  = 3'd4;
  localparam logic [2:0] StSum   = 3'd5;
  localparam logic [2:0] StDiv   = 3'd6;
  localparam logic [2:0] StApply = 3'd7;

  function automatic logic signed [15:0] coeff_pick(input logic [63:0] lo,
                                                    input logic [63:0] hi,
                                                    input logic [2:0]  idx);
    logic [63:0] row;
    row = idx[2] ? hi : lo;
    return row[16*idx[1:0] +: 16];
  endfunction

  logic [2:0]          st_q, st_d;
  logic [2:0]          coeff_idx_q;
  logic                bad_q;
  logic signed [31:0]  delta_q;
  logic signed [15:0]  newer_q, older_q;
  logic [7:0]          low_q;
  logic [7:0]          byte_q;
  logic                ends_q;
  logic                nib_sel_q;

  logic signed [31:0]  pa_q, pb_q;
  logic signed [36:0]  pd_q;
  logic signed [42:0]  pe_q;
  logic signed [32:0]  sum_q;
  logic signed [24:0]  pred_q;
  logic signed [31:0]  dnext_q;

  logic                out_valid_q;
  logic signed [15:0]  sample_q;
  logic                last_q, eob_q, bad_out_q;

  logic signed [15:0]  c1, c2;
  logic [3:0]          nib;
  logic signed [4:0]   nib_s;
  logic [9:0]          adapt;
  logic signed [15:0]  hdr_word;
  logic                slot_free;
  logic                out_load;
  logic signed [15:0]  out_sample_d;
  logic                out_last_d, out_eob_d;

  logic signed [42:0]  pe_bias;
  logic signed [34:0]  pe_div;
  logic signed [31:0]  dnext_d;
  logic signed [32:0]  sum_bias;
  logic signed [37:0]  p_full;
  logic signed [15:0]  p_sat;

  assign c1       = coeff_pick(first_coeff_low_i, first_coeff_high_i, coeff_idx_q);
  assign c2       = coeff_pick(second_coeff_low_i, second_coeff_high_i, coeff_idx_q);
  assign nib      = nib_sel_q ? byte_q[3:0] : byte_q[7:4];
  assign nib_s    = $signed({nib[3], nib});
  assign adapt    = msadpcm_pkg::adapt_factor(nib);
  assign hdr_word = $signed({q_item_i.data, low_q});

  assign slot_free = !out_valid_q || out_ready_i;
  assign q_pop_o   = (st_q == StFetch) && q_valid_i;

  // Division by 256 truncates toward zero, so negative values get a bias.
  assign pe_bias  = pe_q + (pe_q[42] ? 43'sd255 : 43'sd0);
  assign pe_div   = pe_bias[42:8];
  assign sum_bias = sum_q + (sum_q[32] ? 33'sd255 : 33'sd0);
  assign p_full   = 38'(pred_q) + 38'(pd_q);

  always_comb begin
    if (pe_div < 35'sd16) begin
      dnext_d = 32'sd16;
    end else if (pe_div > 35'sd2147483647) begin
      dnext_d = 32'sh7fffffff;
    end else begin
      dnext_d = pe_div[31:0];
    end
  end

  always_comb begin
    if (p_full < -38'sd32768) begin
      p_sat = 16'sh8000;
    end else if (p_full > 38'sd32767) begin
      p_sat = 16'sh7fff;
    end else begin
      p_sat = p_full[15:0];
    end
  end

  always_comb begin
    st_d         = st_q;
    out_load     = 1'b0;
    out_sample_d = p_sat;
    out_last_d   = 1'b0;
    out_eob_d    = 1'b0;
    unique case (st_q)
      StFetch: begin
        if (q_valid_i) begin
          if (q_item_i.kind == msadpcm_pkg::KIND_OLDER) begin
            st_d = StHdr0;
          end else if (q_item_i.kind == msadpcm_pkg::KIND_BODY) begin
            st_d = StMul1;
          end
        end
      end
      StHdr0: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_sample_d = older_q;
          st_d         = StHdr1;
        end
      end
      StHdr1: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_sample_d = newer_q;
          out_last_d   = 1'b1;
          out_eob_d    = ends_q;
          st_d         = StFetch;
        end
      end
      StMul1: st_d = StMul2;
      StMul2: st_d = StSum;
      StSum:  st_d = StDiv;
      StDiv:  st_d = StApply;
      StApply: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_last_d = nib_sel_q;
          out_eob_d  = nib_sel_q && ends_q;
          st_d       = nib_sel_q ? StFetch : StMul1;
        end
      end
      default: st_d = StFetch;
    endcase
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StFetch;
      coeff_idx_q <= 3'd0;
      bad_q       <= 1'b0;
      delta_q     <= 32'sd0;
      newer_q     <= 16'sd0;
      older_q     <= 16'sd0;
      low_q       <= 8'd0;
      nib_sel_q   <= 1'b0;
      ends_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (q_pop_o) begin
        ends_q    <= q_item_i.ends;
        nib_sel_q <= 1'b0;
        unique case (q_item_i.kind)
          msadpcm_pkg::KIND_INDEX: begin
            coeff_idx_q <= q_item_i.data[2:0];
            bad_q       <= |q_item_i.data[7:3];
          end
          msadpcm_pkg::KIND_LOW:   low_q   <= q_item_i.data;
          msadpcm_pkg::KIND_DELTA: delta_q <= 32'(hdr_word);
          msadpcm_pkg::KIND_NEWER: newer_q <= hdr_word;
          msadpcm_pkg::KIND_OLDER: older_q <= hdr_word;
          default: ;
        endcase
      end
      if (st_q == StApply && slot_free) begin
        older_q   <= newer_q;
        newer_q   <= p_sat;
        delta_q   <= dnext_q;
        nib_sel_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Arithmetic pipeline and result payload.
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.kind == msadpcm_pkg::KIND_BODY) begin
      byte_q <= q_item_i.data;
    end
    if (st_q == StMul1) begin
      pa_q <= 32'(newer_q) * 32'(c1);
      pd_q <= 37'(delta_q) * 37'(nib_s);
    end
    if (st_q == StMul2) begin
      pb_q <= 32'(older_q) * 32'(c2);
      pe_q <= 43'(delta_q) * 43'($signed({1'b0, adapt}));
    end
    if (st_q == StSum) begin
      sum_q   <= 33'(pa_q) + 33'(pb_q);
      dnext_q <= dnext_d;
    end
    if (st_q == StDiv) begin
      pred_q <= sum_bias[32:8];
    end
    if (out_load) begin
      sample_q  <= out_sample_d;
      last_q    <= out_last_d;
      eob_q     <= out_eob_d;
      bad_out_q <= bad_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_o        = sample_q;
  assign last_of_run_o   = last_q;
  assign end_of_block_o  = eob_q;
  assign bad_predictor_o = bad_out_q;

endmodule
